/* rtl/core/cabl_pkg.sv */
// Package for the C array byte list parser: phase codes, result kinds,
// character constants and the structs passed between the parser modules.
// Depends on nothing; every other file of the block imports it.
package cabl_pkg;

   localparam logic [3:0] PH_PRELUDE = 4'd0;
   localparam logic [3:0] PH_ARRAY   = 4'd1;
   localparam logic [3:0] PH_COMMA   = 4'd2;
   localparam logic [3:0] PH_ZERO    = 4'd3;
   localparam logic [3:0] PH_DEC     = 4'd4;
   localparam logic [3:0] PH_HEX     = 4'd5;
   localparam logic [3:0] PH_SLASH   = 4'd6;
   localparam logic [3:0] PH_LINE    = 4'd7;
   localparam logic [3:0] PH_BLOCK   = 4'd8;
   localparam logic [3:0] PH_STAR    = 4'd9;
   localparam logic [3:0] PH_DONE    = 4'd10;

   // Resume codes are the low two bits of the list-level phases.
   localparam logic [1:0] RS_PRELUDE = 2'd0;
   localparam logic [1:0] RS_ARRAY   = 2'd1;
   localparam logic [1:0] RS_COMMA   = 2'd2;

   localparam logic [1:0] KIND_BYTE   = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_UPPER_X = 8'h58;
   localparam logic [7:0] CH_LOWER_X = 8'h78;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_VT      = 8'h0B;
   localparam logic [7:0] CH_FF      = 8'h0C;
   localparam logic [7:0] CH_CR      = 8'h0D;

   // Parser state carried from one beat to the next.
   typedef struct packed {
      logic [3:0] phase;
      logic [1:0] resume;
      logic [7:0] acc;
   } parse_state_type;

   // Up to two results caused by one input beat. Only the first one can be
   // an extracted byte; the second is always an accept or reject report.
   typedef struct packed {
      logic [1:0] count;
      logic [1:0] kind0;
      logic [7:0] byte0;
      logic [1:0] kind1;
   } result_pair_type;

endpackage

/* rtl/core/cabl_step.sv */
// Next-state and result logic of the byte list parser for one text beat.
// Purely combinational; uses the phase codes and structs of cabl_pkg.
module cabl_step
   import cabl_pkg::*;
(
   input  parse_state_type state,
   input  logic [7:0]      character,
   input  logic            end_marker,
   output parse_state_type next_state,
   output result_pair_type results
);

   logic       is_dec;
   logic       is_hex_letter;
   logic       is_space;
   logic       is_x;
   logic [3:0] hex_digit;
   logic       emit_byte;
   logic       emit_end;
   logic [1:0] end_kind;
   logic       list_pass;
   logic [1:0] list_phase;

   assign is_dec = (character >= CH_ZERO) && (character <= CH_NINE);
   assign is_hex_letter = ((character >= CH_LOWER_A) && (character <= CH_LOWER_F)) ||
                          ((character >= CH_UPPER_A) && (character <= CH_UPPER_F));
   assign is_space = (character == CH_SPACE) || (character == CH_TAB) ||
                     (character == CH_LF) || (character == CH_VT) ||
                     (character == CH_FF) || (character == CH_CR);
   assign is_x = (character == CH_LOWER_X) || (character == CH_UPPER_X);
   // Letters a-f and A-F both have 1..6 in their low nibble.
   assign hex_digit = is_dec ? character[3:0] : 4'(character[3:0] + 4'd9);

   always_comb begin
      next_state = state;
      emit_byte  = 1'b0;
      emit_end   = 1'b0;
      end_kind   = KIND_REJECT;
      list_pass  = 1'b0;
      list_phase = state.phase[1:0];

      if (end_marker) begin
         emit_byte = (state.phase == PH_ZERO) || (state.phase == PH_DEC) ||
                     (state.phase == PH_HEX);
         emit_end  = (state.phase != PH_DONE);
         next_state.phase  = PH_PRELUDE;
         next_state.resume = RS_PRELUDE;
         next_state.acc    = 8'd0;
      end else begin
         // First pass: number and comment phases.
         case (state.phase)
            PH_PRELUDE, PH_ARRAY, PH_COMMA: begin
               list_pass = 1'b1;
            end
            PH_ZERO: begin
               if (is_x) begin
                  next_state.acc   = 8'd0;
                  next_state.phase = PH_HEX;
               end else if (is_dec) begin
                  next_state.acc   = {4'd0, character[3:0]};
                  next_state.phase = PH_DEC;
               end else begin
                  emit_byte  = 1'b1;
                  list_pass  = 1'b1;
                  list_phase = RS_COMMA;
               end
            end
            PH_DEC: begin
               if (is_dec) begin
                  next_state.acc = 8'((state.acc << 3) + (state.acc << 1) +
                                      {4'd0, character[3:0]});
               end else begin
                  emit_byte  = 1'b1;
                  list_pass  = 1'b1;
                  list_phase = RS_COMMA;
               end
            end
            PH_HEX: begin
               if (is_dec || is_hex_letter) begin
                  next_state.acc = {state.acc[3:0], hex_digit};
               end else begin
                  emit_byte  = 1'b1;
                  list_pass  = 1'b1;
                  list_phase = RS_COMMA;
               end
            end
            PH_SLASH: begin
               if (character == CH_STAR) begin
                  next_state.phase = PH_BLOCK;
               end else if (character == CH_SLASH) begin
                  next_state.phase = PH_LINE;
               end else begin
                  // A lone slash is dropped and this character is retried.
                  list_pass  = 1'b1;
                  list_phase = state.resume;
               end
            end
            PH_LINE: begin
               if ((character == CH_CR) || (character == CH_LF)) begin
                  next_state.phase = {2'b00, state.resume};
               end
            end
            PH_BLOCK: begin
               if (character == CH_STAR) begin
                  next_state.phase = PH_STAR;
               end
            end
            PH_STAR: begin
               if (character == CH_SLASH) begin
                  next_state.phase = {2'b00, state.resume};
               end else if (character != CH_STAR) begin
                  next_state.phase = PH_BLOCK;
               end
            end
            default: begin
            end
         endcase

         // Second pass: list-level handling of the same character.
         if (list_pass) begin
            next_state.phase = {2'b00, list_phase};
            if ((list_phase == RS_PRELUDE) && (character == CH_LBRACE)) begin
               next_state.phase = PH_ARRAY;
            end else if ((list_phase == RS_PRELUDE) && (character == CH_SLASH)) begin
               next_state.resume = RS_PRELUDE;
               next_state.phase  = PH_SLASH;
            end else if ((list_phase == RS_ARRAY) && is_dec) begin
               next_state.acc   = {4'd0, character[3:0]};
               next_state.phase = (character == CH_ZERO) ? PH_ZERO : PH_DEC;
            end else if ((list_phase == RS_COMMA) && (character == CH_COMMA)) begin
               next_state.phase = PH_ARRAY;
            end else if ((list_phase == RS_ARRAY) || (list_phase == RS_COMMA)) begin
               if (character == CH_SLASH) begin
                  next_state.resume = list_phase;
                  next_state.phase  = PH_SLASH;
               end else if (character == CH_RBRACE) begin
                  emit_end         = 1'b1;
                  end_kind         = KIND_ACCEPT;
                  next_state.phase = PH_DONE;
               end else if (!is_space) begin
                  emit_end         = 1'b1;
                  end_kind         = KIND_REJECT;
                  next_state.phase = PH_DONE;
               end
            end
         end
      end
   end

   always_comb begin
      results.kind1 = end_kind;
      if (emit_byte) begin
         results.count = emit_end ? 2'd2 : 2'd1;
         results.kind0 = KIND_BYTE;
         results.byte0 = state.acc;
      end else begin
         results.count = emit_end ? 2'd1 : 2'd0;
         results.kind0 = end_kind;
         results.byte0 = 8'd0;
      end
   end

endmodule

/* rtl/core/cabl_queue.sv */
// Two-entry result queue of the byte list parser. Each entry holds the
// results of one input beat and is drained one result per beat.
// Uses result_pair_type from cabl_pkg.
module cabl_queue
   import cabl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  result_pair_type push_data,
   output logic            has_room,
   output logic            out_valid,
   input  logic            out_ready,
   output logic [1:0]      out_kind,
   output logic [7:0]      out_byte,
   output logic            out_last
);

   result_pair_type slot_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;
   logic            sub_ff, sub_in;
   result_pair_type head;
   logic            pop;

   assign head      = slot_ff[rd_ptr_ff];
   assign out_valid = (count_ff != 2'd0);
   assign has_room  = (count_ff != 2'd2);

   // The second result of a pair is always a report with a zero byte.
   assign out_kind = sub_ff ? head.kind1 : head.kind0;
   assign out_byte = sub_ff ? 8'd0 : head.byte0;
   assign out_last = sub_ff || (head.count == 2'd1);

   assign pop = out_valid && out_ready && out_last;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = 2'(count_ff + {1'b0, push} - {1'b0, pop});
      sub_in    = sub_ff;
      if (out_valid && out_ready) begin
         sub_in = !out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         sub_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sub_ff    <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/c_array_byte_list_parser.sv */
// Each result is registered in the result queue before it is offered on the rsp_ side.
// Throughput: one text beat per cycle while the queue has room; a beat that ends a number
// and the list yields two results, which leave on two consecutive output beats.
// The two-entry result queue sets how far input may run ahead of the output side.
// Reset (synchronous, active high) returns the parser to the prelude and empties the queue.
module c_array_byte_list_parser
   import cabl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // Input channel: one source text byte per beat.
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] character
   input  logic       req_tlast,   // end_marker: end of text, character ignored
   // Result channel.
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] byte_value
   output logic [1:0] rsp_tuser,   // [1:0] kind
   output logic       rsp_tlast    // run_end: last result caused by one input beat
);

   // Parser state. It advances on every accepted beat, so the next accepted beat
   // is evaluated against the updated state.
   logic [3:0]      phase_ff;
   logic [1:0]      resume_ff;
   logic [7:0]      acc_ff;
   parse_state_type cur_state;
   parse_state_type step_state;
   result_pair_type step_results;
   logic            req_accept;
   logic            queue_room;

   assign cur_state.phase  = phase_ff;
   assign cur_state.resume = resume_ff;
   assign cur_state.acc    = acc_ff;

   // The step logic handles both passes a character can take: first the
   // number or comment phase, then the list level when that phase lets go.
   cabl_step u_step (
      .state      (cur_state),
      .character  (req_tdata),
      .end_marker (req_tlast),
      .next_state (step_state),
      .results    (step_results)
   );

   // Input is taken whenever the queue can hold the results of one more beat.
   assign req_tready = queue_room;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_PRELUDE;
         resume_ff <= RS_PRELUDE;
         acc_ff    <= 8'd0;
      end else if (req_accept) begin
         phase_ff  <= step_state.phase;
         resume_ff <= step_state.resume;
         acc_ff    <= step_state.acc;
      end
   end

   // Beats that cause no result, such as skipped text, do not use a queue slot.
   cabl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept && (step_results.count != 2'd0)),
      .push_data (step_results),
      .has_room  (queue_room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_kind  (rsp_tuser),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   // An end marker always leaves the parser in its reset state.
   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> (phase_ff == PH_PRELUDE) && (acc_ff == 8'd0))
      else $error("end marker did not reset the parser");

   // Only list-level phases can be stored as the phase to resume.
   a_resume_code: assert property (@(posedge clock) disable iff (reset)
      (resume_ff == RS_PRELUDE) || (resume_ff == RS_ARRAY) || (resume_ff == RS_COMMA))
      else $error("invalid resume phase");

   // Accept and reject reports carry a zero byte.
   a_report_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != KIND_BYTE) |-> (rsp_tdata == 8'd0))
      else $error("report result with nonzero byte");

   // The phase never leaves the defined codes.
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_DONE)
      else $error("parser phase out of range");
`endif

endmodule

/* tb/tb_c_array_byte_list_parser.sv */
// Self-checking testbench for c_array_byte_list_parser: C-like source text is
// streamed in one byte per beat and every result beat is compared with a local parser model.
// Depends on cabl_pkg and the c_array_byte_list_parser RTL only.
module tb_c_array_byte_list_parser
   import cabl_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Cycles without any accepted beat on either side before the run is abandoned.
   // The longest correct quiet stretch is the deliberate receiver hold-off below.
   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_OFF_LEN  = 300;
   // Extra cycles waited once every expected result has been delivered.
   localparam int DRAIN_CYCLES  = 4;
   localparam int BEATS_PER_RUN = 310;

   // One expected result beat.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic       last;
   } parse_result_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] character
   logic       req_tlast;   // end_marker
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [7:0] byte_value
   logic [1:0] rsp_tuser;   // [1:0] kind
   logic       rsp_tlast;   // run_end

   c_array_byte_list_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Results the parser model has produced that the block has not delivered yet.
   parse_result_type expected_results[$];

   // Model copy of the parser state, updated once per accepted text beat.
   logic [3:0] prs_phase  = PH_PRELUDE;
   logic [1:0] prs_resume = RS_PRELUDE;
   logic [7:0] prs_acc    = 8'h00;

   int error_count   = 0;
   int beats_sent    = 0;
   int stall_cycles  = 0;
   // Chance in percent that the sender idles, or the receiver stalls, in a cycle.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   // A nonzero value asks the receiver process for one long hold-off.
   int hold_off_req  = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Parser model
   // ---------------------------------------------------------------------------

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // Only the six C white space characters count; bytes of 128 and above do not.
   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
             (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
   endfunction

   // Returns {valid, digit value} for one hexadecimal digit of either case.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] lower_val;
      logic [7:0] upper_val;
      lower_val = c - CH_LOWER_A + 8'd10;
      upper_val = c - CH_UPPER_A + 8'd10;
      if (is_digit(c)) return {1'b1, c[3:0]};
      if ((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) return {1'b1, lower_val[3:0]};
      if ((c >= CH_UPPER_A) && (c <= CH_UPPER_F)) return {1'b1, upper_val[3:0]};
      return 5'd0;
   endfunction

   task automatic emit_result(input logic [1:0] kind, input logic [7:0] value);
      parse_result_type res;
      res.kind  = kind;
      res.value = value;
      res.last  = 1'b0;
      expected_results = {expected_results, res};
   endtask

   // A character met where no number is being read: a comment start, the
   // closing brace, white space, or anything else, which rejects the text.
   task automatic list_other(input logic [7:0] c);
      if (c == CH_SLASH) begin
         prs_resume = prs_phase[1:0];
         prs_phase  = PH_SLASH;
      end else if (c == CH_RBRACE) begin
         emit_result(KIND_ACCEPT, 8'h00);
         prs_phase = PH_DONE;
      end else if (!is_blank(c)) begin
         emit_result(KIND_REJECT, 8'h00);
         prs_phase = PH_DONE;
      end
   endtask

   // Works out the results of one accepted beat and queues them in order.
   task automatic predict_beat(input logic [7:0] c, input logic eom);
      int         base;
      int         passes;
      logic       again;
      logic [4:0] hx;
      parse_result_type tail;
      base = expected_results.size();
      if (eom) begin
         // A number still open is flushed before the rejection report.
         if ((prs_phase == PH_ZERO) || (prs_phase == PH_DEC) || (prs_phase == PH_HEX))
            emit_result(KIND_BYTE, prs_acc);
         if (prs_phase != PH_DONE)
            emit_result(KIND_REJECT, 8'h00);
         prs_phase  = PH_PRELUDE;
         prs_resume = RS_PRELUDE;
         prs_acc    = 8'h00;
      end else begin
         // The character that ends a number, or follows a lone slash, is
         // handled again in the phase that follows.
         again  = 1'b1;
         passes = 0;
         while (again && (passes < 3)) begin
            again  = 1'b0;
            passes = passes + 1;
            case (prs_phase)
               PH_PRELUDE: begin
                  if (c == CH_LBRACE) prs_phase = PH_ARRAY;
                  else if (c == CH_SLASH) begin
                     prs_resume = RS_PRELUDE;
                     prs_phase  = PH_SLASH;
                  end
               end
               PH_ARRAY: begin
                  if (c == CH_ZERO) begin
                     prs_acc   = 8'h00;
                     prs_phase = PH_ZERO;
                  end else if (is_digit(c)) begin
                     prs_acc   = c - CH_ZERO;
                     prs_phase = PH_DEC;
                  end else list_other(c);
               end
               PH_COMMA: begin
                  if (c == CH_COMMA) prs_phase = PH_ARRAY;
                  else list_other(c);
               end
               PH_ZERO: begin
                  if ((c == CH_LOWER_X) || (c == CH_UPPER_X)) begin
                     prs_acc   = 8'h00;
                     prs_phase = PH_HEX;
                  end else if (is_digit(c)) begin
                     prs_acc   = c - CH_ZERO;
                     prs_phase = PH_DEC;
                  end else begin
                     emit_result(KIND_BYTE, prs_acc);
                     prs_phase = PH_COMMA;
                     again     = 1'b1;
                  end
               end
               PH_DEC: begin
                  if (is_digit(c)) prs_acc = prs_acc * 8'd10 + (c - CH_ZERO);
                  else begin
                     emit_result(KIND_BYTE, prs_acc);
                     prs_phase = PH_COMMA;
                     again     = 1'b1;
                  end
               end
               PH_HEX: begin
                  hx = hex_digit(c);
                  if (hx[4]) prs_acc = {prs_acc[3:0], hx[3:0]};
                  else begin
                     emit_result(KIND_BYTE, prs_acc);
                     prs_phase = PH_COMMA;
                     again     = 1'b1;
                  end
               end
               PH_SLASH: begin
                  if (c == CH_STAR) prs_phase = PH_BLOCK;
                  else if (c == CH_SLASH) prs_phase = PH_LINE;
                  else begin
                     prs_phase = {2'b00, prs_resume};
                     again     = 1'b1;
                  end
               end
               PH_LINE: begin
                  if ((c == CH_CR) || (c == CH_LF)) prs_phase = {2'b00, prs_resume};
               end
               PH_BLOCK: begin
                  if (c == CH_STAR) prs_phase = PH_STAR;
               end
               PH_STAR: begin
                  if (c == CH_SLASH) prs_phase = {2'b00, prs_resume};
                  else if (c != CH_STAR) prs_phase = PH_BLOCK;
               end
               default: begin
               end
            endcase
         end
      end
      // The last result caused by this beat carries run_end.
      if (expected_results.size() > base) begin
         tail      = expected_results[expected_results.size() - 1];
         tail.last = 1'b1;
         expected_results[expected_results.size() - 1] = tail;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // Sends one text beat. It is entered at a falling edge and returns at the
   // falling edge after the beat was accepted, so that back-to-back beats keep
   // req_tvalid high without a glitch.
   task automatic send_beat(input logic [7:0] c, input logic eom);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eom;
      do @(posedge clock); while (!req_tready);
      predict_beat(c, eom);
      beats_sent = beats_sent + 1;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
   endtask

   // The end marker carries a random character, which the block must ignore.
   task automatic send_end_marker();
      send_beat(8'($urandom_range(255)), 1'b1);
   endtask

   // Drops req_tvalid and waits until every queued result has been delivered.
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [7:0] blank_char();
      case ($urandom_range(5))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_LF;
         3: return CH_VT;
         4: return CH_FF;
         default: return CH_CR;
      endcase
   endfunction

   // Harmless text for declarations and comment bodies: never a brace or a slash.
   function automatic logic [7:0] filler_char();
      case ($urandom_range(4))
         0: return 8'($urandom_range(8'h61, 8'h7A));
         1: return 8'($urandom_range(8'h41, 8'h5A));
         2: return blank_char();
         3: return 8'($urandom_range(8'h80, 8'hFF));
         default: return 8'h3B;
      endcase
   endfunction

   function automatic logic [7:0] hex_char();
      case ($urandom_range(2))
         0: return 8'($urandom_range(CH_ZERO, CH_NINE));
         1: return 8'($urandom_range(CH_LOWER_A, CH_LOWER_F));
         default: return 8'($urandom_range(CH_UPPER_A, CH_UPPER_F));
      endcase
   endfunction

   // Text between tokens: nothing, white space, comments or a lone slash.
   task automatic send_gap();
      int pick;
      pick = $urandom_range(9);
      if ((pick == 4) || (pick == 5) || (pick == 9))
         repeat ($urandom_range(1, 3)) send_beat(blank_char(), 1'b0);
      if ((pick == 6) || (pick == 9)) begin
         send_beat(CH_SLASH, 1'b0);
         send_beat(CH_STAR, 1'b0);
         // Stars inside the body exercise the star-then-not-slash path.
         repeat ($urandom_range(5))
            send_beat(($urandom_range(3) == 0) ? CH_STAR : filler_char(), 1'b0);
         send_beat(CH_STAR, 1'b0);
         send_beat(CH_SLASH, 1'b0);
      end else if (pick == 7) begin
         send_beat(CH_SLASH, 1'b0);
         send_beat(CH_SLASH, 1'b0);
         repeat ($urandom_range(6)) begin
            case ($urandom_range(3))
               0: send_beat(CH_STAR, 1'b0);
               1: send_beat(CH_SLASH, 1'b0);
               default: send_beat(8'($urandom_range(8'h20, 8'hFF)), 1'b0);
            endcase
         end
         send_beat($urandom_range(1) ? CH_LF : CH_CR, 1'b0);
      end else if (pick == 8) begin
         send_beat(CH_SLASH, 1'b0);
      end
   endtask

   // One number: decimal with optional leading zeros, 0x/0X hex, or a bare 0.
   // Long digit strings make the value wrap modulo 256.
   task automatic send_number();
      case ($urandom_range(3))
         0, 1: repeat ($urandom_range(1, 4))
            send_beat(8'($urandom_range(CH_ZERO, CH_NINE)), 1'b0);
         2: begin
            send_beat(CH_ZERO, 1'b0);
            send_beat($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X, 1'b0);
            repeat ($urandom_range(3)) send_beat(hex_char(), 1'b0);
         end
         default: send_beat(CH_ZERO, 1'b0);
      endcase
   endtask

   // Declaration text before the list, or junk after it.
   task automatic send_filler();
      repeat ($urandom_range(6)) send_beat(filler_char(), 1'b0);
      if ($urandom_range(2) == 0) send_gap();
   endtask

   // One source file. Most files are well formed with random content; about
   // one in five may get stray bytes or lose its closing brace.
   task automatic send_random_file();
      logic broken;
      int   n_nums;
      broken = ($urandom_range(99) < 20);
      n_nums = $urandom_range(0, 8);
      send_filler();
      if (broken && ($urandom_range(3) == 0)) send_beat(8'($urandom_range(255)), 1'b0);
      send_beat(CH_LBRACE, 1'b0);
      for (int k = 0; k < n_nums; k++) begin
         send_gap();
         send_number();
         send_gap();
         // The comma after the final number is the optional trailing one.
         if ((k < n_nums - 1) || ($urandom_range(1) == 1)) send_beat(CH_COMMA, 1'b0);
         if (broken && ($urandom_range(5) == 0)) send_beat(8'($urandom_range(255)), 1'b0);
      end
      send_gap();
      if (!(broken && ($urandom_range(2) == 0))) send_beat(CH_RBRACE, 1'b0);
      if ($urandom_range(1) == 1) send_filler();
      send_end_marker();
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Hand-written texts for every result kind and each corner of the grammar.
   task automatic test_directed_lists();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      // A high byte in the prelude is skipped. Then an empty hex number, a
      // decimal with a leading zero, and a lone slash before a digit; the
      // closing brace ends a number and the list in one beat.
      send_beat(8'hFF, 1'b0);
      send_text("{0x,07,/1}");
      // End marker after acceptance: no result.
      send_beat(8'h00, 1'b1);
      // Comma where a number belongs rejects; later bytes are ignored.
      send_text("{,");
      send_beat(8'hFF, 1'b0);
      send_beat(8'hFF, 1'b1);
      // Empty list.
      send_text("{}");
      send_end_marker();
      // A byte of 128 or more is not white space: it ends the number and rejects.
      send_text("{9");
      send_beat(8'h80, 1'b0);
      send_end_marker();
      // Trailing comma before the closing brace.
      send_text("{5,}");
      send_end_marker();
      // Text ending inside a number flushes the number, then rejects.
      send_text("{0");
      send_end_marker();
      wait_results_drained();
   endtask

   task automatic test_random_texts(input int idle_pct, input int stall_pct);
      int target;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      target        = beats_sent + BEATS_PER_RUN;
      while (beats_sent < target) send_random_file();
      wait_results_drained();
   endtask

   // The receiver holds off for a long stretch while a long list keeps coming,
   // so the result queue fills and the block has to stall its input.
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_off_req  = HOLD_OFF_LEN;
      send_beat(CH_LBRACE, 1'b0);
      repeat (40) begin
         send_number();
         send_beat(CH_COMMA, 1'b0);
      end
      send_beat(CH_RBRACE, 1'b0);
      send_end_marker();
      wait_results_drained();
   endtask

   // ---------------------------------------------------------------------------
   // Receiver, checker and watchdog
   // ---------------------------------------------------------------------------

   // Drives rsp_tready at each falling edge. A hold-off request keeps it low
   // for the requested number of cycles, counted here.
   initial begin : rsp_ready_gen
      int hold_len;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req > 0) begin
            hold_len     = hold_off_req;
            hold_off_req = 0;
            rsp_tready <= 1'b0;
            repeat (hold_len) @(negedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Every accepted result beat is checked against the oldest expectation.
   always @(posedge clock) begin : result_check
      parse_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result beat: kind %0d, byte_value %0d, run_end %0d",
                   rsp_tuser, rsp_tdata, rsp_tlast);
            error_count = error_count + 1;
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_tuser !== exp_res.kind) begin
               $error("kind: expected %0d, actual %0d", exp_res.kind, rsp_tuser);
               error_count = error_count + 1;
            end
            if (rsp_tdata !== exp_res.value) begin
               $error("byte_value: expected %0d, actual %0d", exp_res.value, rsp_tdata);
               error_count = error_count + 1;
            end
            if (rsp_tlast !== exp_res.last) begin
               $error("run_end: expected %0d, actual %0d", exp_res.last, rsp_tlast);
               error_count = error_count + 1;
            end
         end
      end
   end

   // Ends the run if neither channel moves a beat for too long.
   always @(posedge clock) begin : stall_watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------

   initial begin : test_sequence
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_lists();
      // Idling phases: none, idle sender, stalling receiver, then both.
      test_random_texts(0, 0);
      test_random_texts(84, 0);
      test_random_texts(0, 84);
      test_random_texts(32, 32);
      test_output_backpressure();

      if ((error_count == 0) && (expected_results.size() == 0))
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* c_array_byte_list_parser.f */
rtl/core/cabl_pkg.sv
rtl/core/cabl_step.sv
rtl/core/cabl_queue.sv
rtl/core/c_array_byte_list_parser.sv
tb/tb_c_array_byte_list_parser.sv
